### sv/selsort_pkg.sv
// shared types and constants for the selection sorter
package selsort_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int CAPACITY_MAX     = 64;
   localparam int CNT_W            = $clog2(CAPACITY_MAX + 1);
   localparam int DATA_W           = 32;
   localparam int NUM_BANKS        = 2;
   localparam int QUEUE_DEPTH      = 2;

   // register map, word index
   localparam logic [0:0] REG_DESCENDING = 1'b0;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_in;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     last_out;
      logic                     dropped;
   } rsp_type;

   // one closed set waiting to be sorted
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             dropped;
      logic             descending;
   } set_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

endpackage

### sv/selsort_ram.sv
// generic single write port ram with registered read
module selsort_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/selsort_front.sv
// front end: loads words of a set into a free bank and hands closed sets on
module selsort_front #(
   parameter int CAPACITY = selsort_pkg::CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  selsort_pkg::req_type        req_payload,
   input  logic                        descending,
   input  selsort_pkg::done_type       done,
   output logic                        wr_en,
   output logic                        wr_bank,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   output logic [selsort_pkg::DATA_W-1:0] wr_data,
   output logic                        push,
   output selsort_pkg::set_type        push_set
);
   import selsort_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 bank_ff, bank_in;
   logic [NUM_BANKS-1:0] busy_ff, busy_in;

   logic             accept;
   logic             room;
   logic [CNT_W-1:0] count_next;
   logic             ovf_next;

   assign req_ready  = !busy_ff[bank_ff];
   assign accept     = req_valid && req_ready;
   assign room       = count_ff < CNT_W'(CAPACITY);
   assign count_next = room ? count_ff + CNT_W'(1) : count_ff;
   assign ovf_next   = ovf_ff | !room;

   assign wr_en   = accept && room;
   assign wr_bank = bank_ff;
   assign wr_addr = count_ff[IDX_W-1:0];
   assign wr_data = req_payload.value;

   assign push                = accept && req_payload.last_in;
   assign push_set.bank       = bank_ff;
   assign push_set.count      = count_next;
   assign push_set.dropped    = ovf_next;
   assign push_set.descending = descending;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      bank_in  = bank_ff;
      busy_in  = busy_ff;
      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end
      if (accept) begin
         count_in = count_next;
         ovf_in   = ovf_next;
         if (req_payload.last_in) begin
            count_in         = '0;
            ovf_in           = 1'b0;
            busy_in[bank_ff] = 1'b1;
            bank_in          = !bank_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         bank_ff  <= 1'b0;
         busy_ff  <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

### sv/selsort_queue.sv
// two-entry queue of closed sets between front and back
module selsort_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  selsort_pkg::set_type push_set,
   input  logic                 pop,
   output logic                 empty,
   output selsort_pkg::set_type head
);
   import selsort_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   set_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     fill_ff, fill_in;
   logic               full;

   assign empty = fill_ff == '0;
   assign full  = fill_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + (PTR_W+1)'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_set;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // the two banks bound the number of closed sets in flight
   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("set queue overrun");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("set queue underrun");

endmodule

### sv/selsort_back.sv
// back end: selection scan over one bank, emits one word per pass
module selsort_back #(
   parameter int CAPACITY = selsort_pkg::CAPACITY_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  selsort_pkg::set_type           q_head,
   output logic                           q_pop,
   output logic                           bank,
   output logic                           rd_en,
   output logic [$clog2(CAPACITY)-1:0]    rd_addr,
   input  logic [selsort_pkg::DATA_W-1:0] rd_data,
   output logic                           wr_en,
   output logic [$clog2(CAPACITY)-1:0]    wr_addr,
   output logic [selsort_pkg::DATA_W-1:0] wr_data,
   output selsort_pkg::done_type          done,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output selsort_pkg::rsp_type           rsp_payload
);
   import selsort_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic                     bank_ff, bank_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic                     drop_ff, drop_in;
   logic                     desc_ff, desc_in;
   logic [IDX_W-1:0]         i_ff, i_in;
   logic [IDX_W-1:0]         j_ff, j_in;
   logic                     rvalid_ff, rvalid_in;
   logic [IDX_W-1:0]         rtag_ff, rtag_in;
   logic signed [DATA_W-1:0] best_ff, best_in;
   logic [IDX_W-1:0]         pick_ff, pick_in;
   logic [DATA_W-1:0]        vi_ff, vi_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic signed [DATA_W-1:0] rdat;
   logic                     better;
   logic                     j_last;
   logic                     i_last;
   logic                     out_load;

   assign rdat     = rd_data;
   assign better   = desc_ff ? (best_ff < rdat) : (rdat < best_ff);
   assign j_last   = CNT_W'(j_ff) == n_ff - CNT_W'(1);
   assign i_last   = CNT_W'(i_ff) == n_ff - CNT_W'(1);
   assign out_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign q_pop   = (state_ff == ST_IDLE) && !q_empty;
   assign bank    = bank_ff;
   assign rd_en   = state_ff == ST_SCAN;
   assign rd_addr = j_ff;
   // the word that sat at the front slot moves into the slot just emitted
   assign wr_en   = out_load;
   assign wr_addr = pick_ff;
   assign wr_data = vi_ff;

   assign done.valid = out_load && i_last;
   assign done.bank  = bank_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      n_in         = n_ff;
      drop_in      = drop_ff;
      desc_in      = desc_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rvalid_in    = 1'b0;
      rtag_in      = j_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      vi_in        = vi_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_in       = rsp_ff;

      // running minimum or maximum over the words read back
      if (rvalid_ff) begin
         if (rtag_ff == i_ff) begin
            best_in = rdat;
            pick_in = rtag_ff;
            vi_in   = rd_data;
         end else if (better) begin
            best_in = rdat;
            pick_in = rtag_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               bank_in  = q_head.bank;
               n_in     = q_head.count;
               drop_in  = q_head.dropped;
               desc_in  = q_head.descending;
               i_in     = '0;
               j_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rvalid_in = 1'b1;
            if (j_last) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load) begin
               rsp_valid_in        = 1'b1;
               rsp_in.sorted_value = best_ff;
               rsp_in.last_out     = i_last;
               rsp_in.dropped      = drop_ff;
               if (i_last) begin
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  j_in     = i_ff + IDX_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      drop_ff <= drop_in;
      desc_ff <= desc_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      rtag_ff <= rtag_in;
      best_ff <= best_in;
      pick_ff <= pick_in;
      vi_ff   <= vi_in;
      rsp_ff  <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff >= i_ff))
      else $error("scan index behind front slot");
   assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> (CNT_W'(rtag_ff) < n_ff))
      else $error("read beyond end of set");
   assert property (@(posedge clock) disable iff (reset)
      done.valid |=> (state_ff == ST_IDLE && rsp_valid_ff && rsp_ff.last_out))
      else $error("set finished without closing word");

endmodule

### sv/selsort_top.sv
// Selection sorter. Words of a set are loaded one per cycle, when the target
// bank is free, into one of two banks while the other bank may still be
// sorting; the word marked last closes the set, and at most CAPACITY words
// are kept (later ones are discarded and flag the whole run as dropped).
// Sorting is a selection scan over the single read port of the bank: for a
// set of n words, pass k reads the n-k words still unsorted and emits the
// best one. Order is ascending, or descending when register 0 bit 0 is set;
// the setting is taken when the set closes.
module selection_sorter_top #(
   parameter int CAPACITY = selsort_pkg::CAPACITY_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  selsort_pkg::req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output selsort_pkg::rsp_type rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [1:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import selsort_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);

   logic       desc_ff, desc_in;
   logic       csr_write;
   logic [0:0] reg_index;

   logic              f_wr_en, f_wr_bank;
   logic [IDX_W-1:0]  f_wr_addr;
   logic [DATA_W-1:0] f_wr_data;
   logic              push;
   set_type           push_set;
   logic              q_pop, q_empty;
   set_type           q_head;
   done_type          done;

   logic              b_bank, b_rd_en, b_wr_en;
   logic [IDX_W-1:0]  b_rd_addr, b_wr_addr;
   logic [DATA_W-1:0] b_wr_data;
   logic [DATA_W-1:0] bank_rd_data [NUM_BANKS];

   // only one register word exists
   assign reg_index = 1'b0;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign desc_in   = (csr_write && reg_index == REG_DESCENDING) ? pwdata[0] : desc_ff;
   assign prdata    = {31'b0, desc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_ff <= 1'b0;
      end else begin
         desc_ff <= desc_in;
      end
   end

   selsort_front #(.CAPACITY(CAPACITY)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .descending  (desc_ff),
      .done        (done),
      .wr_en       (f_wr_en),
      .wr_bank     (f_wr_bank),
      .wr_addr     (f_wr_addr),
      .wr_data     (f_wr_data),
      .push        (push),
      .push_set    (push_set)
   );

   selsort_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_set (push_set),
      .pop      (q_pop),
      .empty    (q_empty),
      .head     (q_head)
   );

   // front and back never own the same bank at once
   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic              front_owns;
      logic              back_owns;
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;

      assign front_owns = f_wr_en && (f_wr_bank == 1'(b));
      assign back_owns  = b_bank == 1'(b);
      assign we         = front_owns || (back_owns && b_wr_en);
      assign waddr      = front_owns ? f_wr_addr : b_wr_addr;
      assign wdata      = front_owns ? f_wr_data : b_wr_data;

      selsort_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (waddr),
         .wr_data (wdata),
         .rd_en   (back_owns && b_rd_en),
         .rd_addr (b_rd_addr),
         .rd_data (bank_rd_data[b])
      );
   end

   selsort_back #(.CAPACITY(CAPACITY)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .bank        (b_bank),
      .rd_en       (b_rd_en),
      .rd_addr     (b_rd_addr),
      .rd_data     (bank_rd_data[b_bank]),
      .wr_en       (b_wr_en),
      .wr_addr     (b_wr_addr),
      .wr_data     (b_wr_data),
      .done        (done),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
